@@ rtl/core/spac_pkg.sv @@
// Shared types and constants of the sprite patch alpha compositor.
package spac_pkg;

	localparam int unsigned CHAN_W  = 8;
	localparam int unsigned IN_W    = 8 * CHAN_W;
	localparam int unsigned OUT_W   = 4 * CHAN_W;
	localparam int unsigned IUSER_W = 2;

	localparam logic [CHAN_W-1:0] FULL_ALPHA = 8'd255;
	localparam logic [CHAN_W-1:0] ZERO_ALPHA = 8'd0;

	// Pass that an input word belongs to
	typedef enum logic {
		OP_SCAN  = 1'b0,
		OP_BLEND = 1'b1
	} op_t;

	// Input pixel pair, patch in RGBA order and destination in BGRA order
	typedef struct packed {
		logic [CHAN_W-1:0] dest_alpha;
		logic [CHAN_W-1:0] dest_red;
		logic [CHAN_W-1:0] dest_green;
		logic [CHAN_W-1:0] dest_blue;
		logic [CHAN_W-1:0] patch_alpha;
		logic [CHAN_W-1:0] patch_blue;
		logic [CHAN_W-1:0] patch_green;
		logic [CHAN_W-1:0] patch_red;
	} pair_t;

	// Resulting destination pixel, BGRA order
	typedef struct packed {
		logic [CHAN_W-1:0] out_alpha;
		logic [CHAN_W-1:0] out_red;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_blue;
	} pix_t;

	// Per-rectangle decisions gathered in the scan pass
	typedef struct packed {
		logic patch_empty;
		logic dest_opaque;
	} flags_t;

endpackage

@@ rtl/core/spac_flags.sv @@
// Scan pass flag tracker: patch empty and destination opaque.
module spac_flags (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        upd,
	input  logic                        first_of_sprite,
	input  logic [spac_pkg::CHAN_W-1:0] patch_alpha,
	input  logic [spac_pkg::CHAN_W-1:0] dest_alpha,
	output spac_pkg::flags_t            flags
);

	spac_pkg::flags_t flags_q;
	spac_pkg::flags_t base;
	spac_pkg::flags_t nxt;

	// Restart both flags on the first scan word of a rectangle, then fold in this word
	always_comb begin
		base = first_of_sprite ? spac_pkg::flags_t'{patch_empty: 1'b1, dest_opaque: 1'b1} :
			flags_q;
		nxt.patch_empty = base.patch_empty && (patch_alpha == spac_pkg::ZERO_ALPHA);
		nxt.dest_opaque = base.dest_opaque && (dest_alpha == spac_pkg::FULL_ALPHA);
	end

	// Hold flags between scan words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '{patch_empty: 1'b1, dest_opaque: 1'b1};
		end else if (upd) begin
			flags_q <= nxt;
		end
	end

	assign flags = flags_q;

endmodule

@@ rtl/core/spac_blend.sv @@
// Blend datapath: pass-through, replace or source-over mix of one pixel pair.
module spac_blend (
	input  spac_pkg::pair_t  pair,
	input  spac_pkg::flags_t flags,
	output spac_pkg::pix_t   pix,
	output logic             sprite_changed
);

	logic [spac_pkg::CHAN_W-1:0]   inv_a;
	logic [2*spac_pkg::CHAN_W-1:0] mix_b;
	logic [2*spac_pkg::CHAN_W-1:0] mix_g;
	logic [2*spac_pkg::CHAN_W-1:0] mix_r;
	logic [spac_pkg::CHAN_W:0]     a_sum;
	logic [spac_pkg::CHAN_W-1:0]   a_mix;

	// Weight each channel by alpha; the sum stays below 2^16
	always_comb begin
		inv_a = spac_pkg::FULL_ALPHA - pair.patch_alpha;
		mix_b = pair.dest_blue  * inv_a + pair.patch_blue  * pair.patch_alpha;
		mix_g = pair.dest_green * inv_a + pair.patch_green * pair.patch_alpha;
		mix_r = pair.dest_red   * inv_a + pair.patch_red   * pair.patch_alpha;
		a_sum = {1'b0, pair.dest_alpha} + {1'b0, pair.patch_alpha};
		// Saturate alpha at full
		if (pair.patch_alpha == spac_pkg::FULL_ALPHA || a_sum[spac_pkg::CHAN_W]) begin
			a_mix = spac_pkg::FULL_ALPHA;
		end else begin
			a_mix = a_sum[spac_pkg::CHAN_W-1:0];
		end
	end

	// Select the result by the scan decisions
	always_comb begin
		sprite_changed = !flags.patch_empty;
		if (flags.patch_empty || (flags.dest_opaque && pair.patch_alpha == spac_pkg::ZERO_ALPHA)) begin
			pix = '{out_alpha: pair.dest_alpha, out_red: pair.dest_red,
				out_green: pair.dest_green, out_blue: pair.dest_blue};
		end else if (!flags.dest_opaque) begin
			pix = '{out_alpha: pair.patch_alpha, out_red: pair.patch_red,
				out_green: pair.patch_green, out_blue: pair.patch_blue};
		end else begin
			pix = '{out_alpha: a_mix,
				out_red:   mix_r[2*spac_pkg::CHAN_W-1:spac_pkg::CHAN_W],
				out_green: mix_g[2*spac_pkg::CHAN_W-1:spac_pkg::CHAN_W],
				out_blue:  mix_b[2*spac_pkg::CHAN_W-1:spac_pkg::CHAN_W]};
		end
	end

endmodule

@@ rtl/core/sprite_patch_alpha_compositor.sv @@
// Top level of the sprite patch alpha compositor: input register, blend, output register.
// Takes one pixel-pair word per cycle and returns one result word per blend-pass word:
// an input register feeds the flag tracker and the blend datapath (six 8x8
// multiplies and a saturating alpha add), whose result lands in an output
// register. Scan-pass words (tuser bit 0 low) update the rectangle flags and
// produce no output; blend-pass words see the flags left by the scan words
// before them. Throughput is one word per cycle while the output side keeps
// taking words; a full output register stalls only blend-pass words.
module sprite_patch_alpha_compositor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// patch_red, patch_green, patch_blue, patch_alpha,
	// dest_blue, dest_green, dest_red, dest_alpha
	input  logic [spac_pkg::IN_W-1:0]     s_tdata,
	// operation, first_of_sprite
	input  logic [spac_pkg::IUSER_W-1:0]  s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// out_blue, out_green, out_red, out_alpha
	output logic [spac_pkg::OUT_W-1:0]    m_tdata,
	// sprite_changed
	output logic [0:0]                    m_tuser
);

	logic              valid_s1;
	spac_pkg::op_t     op_s1;
	logic              first_s1;
	spac_pkg::pair_t   pair_s1;
	logic              adv_s1;
	logic              scan_adv;
	spac_pkg::flags_t  flags;
	spac_pkg::pix_t    pix;
	logic              changed;
	logic              valid_s2;
	spac_pkg::pix_t    pix_s2;
	logic              changed_s2;

	// Advance stage one: scan words always leave, blend words need output room
	assign adv_s1   = valid_s1 && (op_s1 == spac_pkg::OP_SCAN || !valid_s2 || m_tready);
	assign scan_adv = adv_s1 && op_s1 == spac_pkg::OP_SCAN;
	assign s_tready = !valid_s1 || adv_s1;

	// Capture the input word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1    <= spac_pkg::op_t'(s_tuser[0]);
			first_s1 <= s_tuser[1];
			pair_s1  <= spac_pkg::pair_t'(s_tdata);
		end
	end

	spac_flags u_flags (
		.clk             (clk),
		.arst_n          (arst_n),
		.upd             (scan_adv),
		.first_of_sprite (first_s1),
		.patch_alpha     (pair_s1.patch_alpha),
		.dest_alpha      (pair_s1.dest_alpha),
		.flags           (flags)
	);

	spac_blend u_blend (
		.pair           (pair_s1),
		.flags          (flags),
		.pix            (pix),
		.sprite_changed (changed)
	);

	// Load the output register with blend results, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1 && op_s1 == spac_pkg::OP_BLEND) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && op_s1 == spac_pkg::OP_BLEND) begin
			pix_s2     <= pix;
			changed_s2 <= changed;
		end
	end

	assign m_tvalid   = valid_s2;
	assign m_tdata    = pix_s2;
	assign m_tuser[0] = changed_s2;

`ifndef SYNTHESIS
	// A blend word never overwrites a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && op_s1 == spac_pkg::OP_BLEND |-> !valid_s2 || m_tready)
		else $error("blend result overwrote a pending output word");

	// The changed flag of a result follows the patch flag it was blended with
	a_changed: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && op_s1 == spac_pkg::OP_BLEND |=> m_tuser[0] == !$past(flags.patch_empty))
		else $error("sprite_changed does not match the patch flag");

	// An empty patch passes the destination through unchanged
	a_passthru: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && op_s1 == spac_pkg::OP_BLEND && flags.patch_empty
		|=> m_tdata == $past(pair_s1[spac_pkg::IN_W-1:spac_pkg::OUT_W]))
		else $error("empty patch altered the destination");

	// A first scan word restarts both flags from that word alone
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		scan_adv && first_s1 |=>
		flags.patch_empty == ($past(pair_s1.patch_alpha) == spac_pkg::ZERO_ALPHA) &&
		flags.dest_opaque == ($past(pair_s1.dest_alpha) == spac_pkg::FULL_ALPHA))
		else $error("flags not restarted on first scan word");

	// Blend words leave the flags alone
	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!scan_adv |=> $stable(flags))
		else $error("flags changed outside the scan pass");
`endif

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the sprite patch alpha compositor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF    = 6;
	localparam int RESET_CYC   = 7;
	localparam int TOTAL_WORDS = 1225;
	localparam int HOLD_CYC    = 150;
	localparam int IDLE_LIMIT  = 2000;
	localparam int TAIL_CYC    = 8;

	// One expected output word: pixel plus the changed flag
	typedef struct packed {
		spac_pkg::pix_t pix;
		logic           changed;
	} result_t;

	// Directed row: input fields, then an optional typed-in expectation
	typedef struct packed {
		spac_pkg::op_t op;
		logic          first;
		logic [7:0]    pr, pg, pb, pa;
		logic [7:0]    db, dg, dr, da;
		logic          typed;
		logic [7:0]    eb, eg, er, ea;
		logic          echg;
	} stim_row_t;

	localparam int N_DIRECTED = 24;
	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		// blend right after reset: flags at reset, pixel passes through
		'{spac_pkg::OP_BLEND, 0,   9,   8,   7,   6,  11,  22,  33,  44, 1,  11,  22,  33,  44, 0},
		// empty patch over opaque destination
		'{spac_pkg::OP_SCAN,  1, 200, 100,  50,   0,   1,   2,   3, 255, 0,   0,   0,   0,   0, 0},
		'{spac_pkg::OP_SCAN,  0, 255, 255, 255,   0,   0,   0,   0, 255, 0,   0,   0,   0,   0, 0},
		'{spac_pkg::OP_BLEND, 0, 255, 255, 255, 255,   5,   6,   7,   8, 1,   5,   6,   7,   8, 0},
		// non-empty patch over opaque destination: true blend
		'{spac_pkg::OP_SCAN,  1,  10,  20,  30, 255,   0,   0,   0, 255, 0,   0,   0,   0,   0, 0},
		'{spac_pkg::OP_SCAN,  0,   0,   0,   0,   0, 255, 255, 255, 255, 0,   0,   0,   0,   0, 0},
		'{spac_pkg::OP_BLEND, 0, 255, 255, 255, 255,   0,   0,   0, 255, 0,   0,   0,   0,   0, 0},
		'{spac_pkg::OP_BLEND, 0,   0,   0,   0, 255, 255, 255, 255, 255, 0,   0,   0,   0,   0, 0},
		// zero patch alpha keeps the destination but still flags a change
		'{spac_pkg::OP_BLEND, 0,  77,  88,  99,   0,  12,  34,  56,  78, 1,  12,  34,  56,  78, 1},
		// first mark in the blend pass must be ignored
		'{spac_pkg::OP_BLEND, 1, 200, 150, 100,   1, 255, 255, 255, 255, 0,   0,   0,   0,   0, 0},
		'{spac_pkg::OP_BLEND, 0, 255,   0, 255, 128,   0, 255,   0, 200, 0,   0,   0,   0,   0, 0},
		'{spac_pkg::OP_BLEND, 0,  40,  80, 120, 100, 200, 100,  50, 100, 0,   0,   0,   0,   0, 0},
		'{spac_pkg::OP_BLEND, 0, 255, 255, 255, 254, 255, 255, 255,   1, 0,   0,   0,   0,   0, 0},
		// empty patch wins over a translucent destination
		'{spac_pkg::OP_SCAN,  1,   0,   0,   0,   0,  10,  10,  10, 254, 0,   0,   0,   0,   0, 0},
		'{spac_pkg::OP_BLEND, 0,   1,   2,   3,   4,   9,   8,   7,   6, 1,   9,   8,   7,   6, 0},
		// translucent destination: patch replaces it
		'{spac_pkg::OP_SCAN,  1,   0,   0,   0,   1,   0,   0,   0,   0, 0,   0,   0,   0,   0, 0},
		'{spac_pkg::OP_SCAN,  0, 255, 255, 255, 255, 255, 255, 255, 255, 0,   0,   0,   0,   0, 0},
		'{spac_pkg::OP_BLEND, 0,  10,  20,  30,  40,   1,   2,   3,   4, 1,  30,  20,  10,  40, 1},
		'{spac_pkg::OP_BLEND, 0, 255, 128,   0,   0, 255, 255, 255, 255, 1,   0, 128, 255,   0, 1},
		'{spac_pkg::OP_BLEND, 0,   0,   0,   0, 255,   0,   0,   0,   0, 1,   0,   0,   0, 255, 1},
		// scan word without a first mark keeps the sticky flags
		'{spac_pkg::OP_SCAN,  0,   5,   5,   5,   0, 255, 255, 255, 255, 0,   0,   0,   0,   0, 0},
		'{spac_pkg::OP_BLEND, 0,   1,   2,   3, 200,   0,   0,   0, 255, 1,   3,   2,   1, 200, 1},
		// new rectangle restarts both flags
		'{spac_pkg::OP_SCAN,  1, 128,  64,  32,  16, 255, 255, 255, 255, 0,   0,   0,   0,   0, 0},
		'{spac_pkg::OP_BLEND, 0, 128,  64,  32,  16, 100, 100, 100, 255, 0,   0,   0,   0,   0, 0}
	};

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [spac_pkg::IN_W-1:0]     s_tdata;
	logic [spac_pkg::IUSER_W-1:0]  s_tuser;
	logic                          m_tvalid;
	logic                          m_tready;
	logic [spac_pkg::OUT_W-1:0]    m_tdata;
	logic [0:0]                    m_tuser;

	// Predictor state and bookkeeping
	spac_pkg::flags_t rect_flags;
	result_t          pending_pixels [$];
	int               words_sent;
	int               results_seen;
	int               error_count;
	int               burst_left;
	int               n_scan, n_kept, n_replaced, n_mixed;
	logic             hold_pending;
	int               idle_cycles;

	sprite_patch_alpha_compositor dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Free-running clock
	always begin
		clk = 1'b0;
		#CLK_HALF;
		clk = 1'b1;
		#CLK_HALF;
	end

	// Weighted channel mix: (d*(255-a)+p*a)>>8
	function automatic logic [7:0] mix_channel(logic [7:0] d, logic [7:0] p, logic [7:0] a);
		logic [15:0] acc;
		acc = 16'(d) * 16'(spac_pkg::FULL_ALPHA - a) + 16'(p) * 16'(a);
		return acc[15:8];
	endfunction

	// Advance the rectangle flags and work out the output word, if any
	function automatic logic composite_pixel(spac_pkg::op_t op, logic first,
		spac_pkg::pair_t p, output result_t r);
		logic [8:0] alpha_sum;
		r = '0;
		if (op == spac_pkg::OP_SCAN) begin
			if (first) rect_flags = '{patch_empty: 1'b1, dest_opaque: 1'b1};
			if (p.patch_alpha != spac_pkg::ZERO_ALPHA) rect_flags.patch_empty = 1'b0;
			if (p.dest_alpha != spac_pkg::FULL_ALPHA) rect_flags.dest_opaque = 1'b0;
			n_scan++;
			return 1'b0;
		end
		r.changed = !rect_flags.patch_empty;
		if (rect_flags.patch_empty ||
			(rect_flags.dest_opaque && p.patch_alpha == spac_pkg::ZERO_ALPHA)) begin
			r.pix = '{out_alpha: p.dest_alpha, out_red: p.dest_red,
				out_green: p.dest_green, out_blue: p.dest_blue};
			n_kept++;
		end else if (!rect_flags.dest_opaque) begin
			r.pix = '{out_alpha: p.patch_alpha, out_red: p.patch_red,
				out_green: p.patch_green, out_blue: p.patch_blue};
			n_replaced++;
		end else begin
			alpha_sum = {1'b0, p.dest_alpha} + {1'b0, p.patch_alpha};
			r.pix.out_blue  = mix_channel(p.dest_blue, p.patch_blue, p.patch_alpha);
			r.pix.out_green = mix_channel(p.dest_green, p.patch_green, p.patch_alpha);
			r.pix.out_red   = mix_channel(p.dest_red, p.patch_red, p.patch_alpha);
			r.pix.out_alpha = (p.patch_alpha == spac_pkg::FULL_ALPHA || alpha_sum > 9'd255) ?
				spac_pkg::FULL_ALPHA : alpha_sum[7:0];
			n_mixed++;
		end
		return 1'b1;
	endfunction

	// Offer one word, wait for acceptance, log the expectation, then maybe idle
	task automatic offer_word(spac_pkg::op_t op, logic first, spac_pkg::pair_t p,
		logic typed, result_t want);
		result_t predicted;
		int gap;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= p;
		s_tuser  <= {first, op};
		do @(posedge clk); while (!s_tready);
		words_sent++;
		if (composite_pixel(op, first, p, predicted))
			pending_pixels.push_back(typed ? want : predicted);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) :
				$urandom_range(0, 12);
		end
	endtask

	// Stop offering and hold until every expected word has come back
	task automatic wait_results_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
	endtask

	function automatic void check_channel(string name, logic [7:0] exp_v, logic [7:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
			error_count++;
		end
	endfunction

	// Receiver: random ready pattern, with one long hold-off on request
	initial begin
		int rx_mode;
		int rx_left;
		m_tready = 1'b0;
		rx_mode  = 0;
		rx_left  = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYC - 1) @(negedge clk);
			end else begin
				if (rx_left == 0) begin
					rx_mode = $urandom_range(0, 3);
					rx_left = $urandom_range(20, 80);
				end
				rx_left--;
				case (rx_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= ~m_tready;
				endcase
			end
		end
	end

	// Check each accepted output word against the oldest expectation
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.pix     = spac_pkg::pix_t'(m_tdata);
			got.changed = m_tuser[0];
			results_seen++;
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected output word: actual %h changed %0d",
					$time, got.pix, got.changed);
				error_count++;
			end else begin
				want = pending_pixels.pop_front();
				check_channel("out_blue", want.pix.out_blue, got.pix.out_blue);
				check_channel("out_green", want.pix.out_green, got.pix.out_green);
				check_channel("out_red", want.pix.out_red, got.pix.out_red);
				check_channel("out_alpha", want.pix.out_alpha, got.pix.out_alpha);
				check_channel("sprite_changed", 8'(want.changed), 8'(got.changed));
			end
		end
	end

	// Watchdog: end the run when neither side moves a word for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no progress for %0d cycles, %0d words still expected",
					$time, IDLE_LIMIT, pending_pixels.size());
				$display("sprite_patch_alpha_compositor regression: fail");
				$finish;
			end
		end
	end

	// Main stimulus
	initial begin
		stim_row_t       row;
		spac_pkg::pair_t p;
		spac_pkg::pair_t rect [$];
		result_t         want;
		int              n_pix;
		int              n_blend;
		logic            empty_patch;
		logic            opaque_dest;
		logic            mark_first;
		logic            hold_done;
		logic            drain_done;

		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		hold_pending = 1'b0;
		rect_flags   = '{patch_empty: 1'b1, dest_opaque: 1'b1};
		words_sent   = 0;
		results_seen = 0;
		error_count  = 0;
		burst_left   = 0;
		idle_cycles  = 0;
		n_scan       = 0;
		n_kept       = 0;
		n_replaced   = 0;
		n_mixed      = 0;
		hold_done    = 1'b0;
		drain_done   = 1'b0;
		repeat (RESET_CYC) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Walk the directed rows
		for (int i = 0; i < N_DIRECTED; i++) begin
			row = DIRECTED[i];
			p = '{dest_alpha: row.da, dest_red: row.dr, dest_green: row.dg,
				dest_blue: row.db, patch_alpha: row.pa, patch_blue: row.pb,
				patch_green: row.pg, patch_red: row.pr};
			want.pix = '{out_alpha: row.ea, out_red: row.er, out_green: row.eg,
				out_blue: row.eb};
			want.changed = row.echg;
			offer_word(row.op, row.first, p, row.typed, want);
		end

		// Random rectangles with scan and blend passes, plus some noise
		while (words_sent < TOTAL_WORDS) begin
			if (!hold_done && words_sent > 400) begin
				hold_pending = 1'b1;
				hold_done    = 1'b1;
			end
			if (!drain_done && words_sent > 800) begin
				wait_results_drained();
				drain_done = 1'b1;
			end
			if ($urandom_range(0, 9) == 0) begin
				// noise: fully random words
				repeat ($urandom_range(1, 4)) begin
					p = spac_pkg::pair_t'({$urandom, $urandom});
					offer_word(spac_pkg::op_t'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), p, 1'b0, '0);
				end
			end else begin
				n_pix = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 24) :
					$urandom_range(1, 6);
				empty_patch = ($urandom_range(0, 3) == 0);
				opaque_dest = ($urandom_range(0, 2) != 0);
				mark_first  = ($urandom_range(0, 7) != 0);
				rect.delete();
				for (int i = 0; i < n_pix; i++) begin
					p = spac_pkg::pair_t'({$urandom, $urandom});
					if (empty_patch) begin
						p.patch_alpha = spac_pkg::ZERO_ALPHA;
					end else begin
						case ($urandom_range(0, 5))
							0: p.patch_alpha = spac_pkg::ZERO_ALPHA;
							1: p.patch_alpha = spac_pkg::FULL_ALPHA;
							2: p.patch_alpha = 8'd1;
							3: p.patch_alpha = 8'd254;
							default: p.patch_alpha = 8'($urandom);
						endcase
					end
					if (opaque_dest || $urandom_range(0, 1) == 0)
						p.dest_alpha = spac_pkg::FULL_ALPHA;
					rect.push_back(p);
				end
				// scan pass, with an occasional stray first mark
				for (int i = 0; i < n_pix; i++)
					offer_word(spac_pkg::OP_SCAN,
						(i == 0) ? mark_first : ($urandom_range(0, 15) == 0),
						rect[i], 1'b0, '0);
				// blend pass: usually one, sometimes none or two
				case ($urandom_range(0, 9))
					0: n_blend = 0;
					1: n_blend = 2;
					default: n_blend = 1;
				endcase
				repeat (n_blend) begin
					for (int i = 0; i < n_pix; i++)
						offer_word(spac_pkg::OP_BLEND, ($urandom_range(0, 3) == 0), rect[i],
							1'b0, '0);
				end
			end
		end

		wait_results_drained();
		repeat (TAIL_CYC) @(posedge clk);

		$display("Sent %0d words (%0d scan), checked %0d output words, %0d mismatches",
			words_sent, n_scan, results_seen, error_count);
		$display("Blend outcomes: %0d kept, %0d replaced, %0d mixed; one long output stall",
			n_kept, n_replaced, n_mixed);
		if (error_count == 0) begin
			$display("sprite_patch_alpha_compositor regression: pass");
		end else begin
			$display("sprite_patch_alpha_compositor regression: fail");
		end
		$finish;
	end

endmodule
